[rtl/core/sme_pkg.sv]
// Shared types and codes for the stack machine execute block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sme_pkg;

    // Input item as it arrives on the port
    typedef struct packed {
        logic               cmd;
        logic [4:0]         opcode;
        logic [9:0]         arg_a;
        logic [9:0]         arg_b;
        logic [11:0]        instr_addr;
        logic signed [31:0] read_value;
        logic signed [31:0] const_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [11:0]        next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [2:0]         status;
    } t_out_item;

    // Command codes
    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_DEF  = 1'b1;

    // Opcodes
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_LDC    = 5'd1;
    localparam logic [4:0] OP_LDV    = 5'd2;
    localparam logic [4:0] OP_STR    = 5'd3;
    localparam logic [4:0] OP_JMP    = 5'd4;
    localparam logic [4:0] OP_JMPF   = 5'd5;
    localparam logic [4:0] OP_CALL   = 5'd6;
    localparam logic [4:0] OP_ADD    = 5'd7;
    localparam logic [4:0] OP_SUB    = 5'd8;
    localparam logic [4:0] OP_MULT   = 5'd9;
    localparam logic [4:0] OP_DIV    = 5'd10;
    localparam logic [4:0] OP_AND    = 5'd11;
    localparam logic [4:0] OP_OR     = 5'd12;
    localparam logic [4:0] OP_NEG    = 5'd13;
    localparam logic [4:0] OP_CME    = 5'd14;
    localparam logic [4:0] OP_CMA    = 5'd15;
    localparam logic [4:0] OP_CEQ    = 5'd16;
    localparam logic [4:0] OP_CDIF   = 5'd17;
    localparam logic [4:0] OP_CMEQ   = 5'd18;
    localparam logic [4:0] OP_CMAQ   = 5'd19;
    localparam logic [4:0] OP_RD     = 5'd20;
    localparam logic [4:0] OP_RETURN = 5'd21;
    localparam logic [4:0] OP_PRN    = 5'd22;
    localparam logic [4:0] OP_INV    = 5'd23;
    localparam logic [4:0] OP_ALLOC  = 5'd24;
    localparam logic [4:0] OP_DALLOC = 5'd25;
    localparam logic [4:0] OP_HLT    = 5'd26;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVER    = 3'd1;
    localparam logic [2:0] ST_UNDER   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_ADDR    = 3'd4;
    localparam logic [2:0] ST_HALT    = 3'd5;

    // Instruction class decided by the front end
    typedef enum logic [3:0] {
        C_NOP, C_DEF, C_PUSHIN, C_LDV, C_STR, C_JMP, C_JMPF, C_CALL,
        C_BIN, C_UN, C_ALLOC, C_DALLOC, C_HLT
    } t_cls;

    // Queue entry between front and back end
    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_qent;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_be_status;

    // Multiply / divide unit request
    typedef enum logic [1:0] {MD_MUL, MD_SDIV, MD_UMOD} t_mdop;

    typedef struct packed {
        logic  start;
        t_mdop op;
    } t_md_req;

    localparam int QDEPTH = 2;

endpackage

[rtl/core/sme_front.sv]
// Front end: takes input items and classifies them for the back end.
// Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_front import sme_pkg::*; (
    input  t_in_item   i_item,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_q_full,
    input  t_be_status i_status,
    output logic       o_push,
    output t_qent      o_ent
);

    // hold off while the queue is full or the memory is being cleared
    assign o_stall = i_q_full || i_status.clearing;
    assign o_push  = i_valid && !o_stall;

    t_cls cls;

    // opcode classification
    always_comb begin
        if (i_item.cmd == CMD_DEF) begin
            cls = C_DEF;
        end else begin
            unique case (i_item.opcode)
                OP_LDC, OP_RD:                       cls = C_PUSHIN;
                OP_LDV:                              cls = C_LDV;
                OP_STR:                              cls = C_STR;
                OP_JMP:                              cls = C_JMP;
                OP_JMPF:                             cls = C_JMPF;
                OP_CALL:                             cls = C_CALL;
                OP_ADD, OP_SUB, OP_MULT, OP_DIV,
                OP_AND, OP_OR, OP_CME, OP_CMA,
                OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ:   cls = C_BIN;
                OP_NEG, OP_RETURN, OP_PRN, OP_INV:   cls = C_UN;
                OP_ALLOC:                            cls = C_ALLOC;
                OP_DALLOC:                           cls = C_DALLOC;
                OP_HLT:                              cls = C_HLT;
                default:                             cls = C_NOP;
            endcase
        end
    end

    assign o_ent = '{cls: cls, item: i_item};

endmodule

[rtl/core/sme_queue.sv]
// Short queue of classified items between front and back end.
// Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_queue import sme_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_qent            r_buf [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rp];

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        ptr_inc = (p == QAW'(QDEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[rtl/core/sme_muldiv.sv]
// Iterative multiply / divide unit, one bit per cycle.
// Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_muldiv import sme_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_md_req               i_req,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_result
);

    localparam int WW = WORD_WIDTH;
    localparam int CW = $clog2(WW) + 1;

    logic          r_busy, r_done, r_neg;
    t_mdop         r_op;
    logic [CW-1:0] r_cnt;
    logic [WW-1:0] r_x, r_y, r_acc;

    logic [WW:0]   rem_sh;
    logic          fits;
    logic [WW-1:0] ma, mb;

    assign ma     = i_a[WW-1] ? (WW'(0) - i_a) : i_a;
    assign mb     = i_b[WW-1] ? (WW'(0) - i_b) : i_b;
    assign rem_sh = {r_acc, r_y[WW-1]};
    assign fits   = (rem_sh >= {1'b0, r_x});

    assign o_done = r_done;
    always_comb begin
        unique case (r_op)
            MD_MUL:  o_result = r_acc;
            MD_SDIV: o_result = r_neg ? (WW'(0) - r_y) : r_y;
            MD_UMOD: o_result = r_acc;
            default: o_result = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= MD_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // load operands
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= '0;
                r_acc  <= '0;
                unique case (i_req.op)
                    MD_MUL: begin
                        r_x   <= i_a;
                        r_y   <= i_b;
                        r_neg <= 1'b0;
                    end
                    MD_SDIV: begin
                        r_x   <= mb;
                        r_y   <= ma;
                        r_neg <= i_a[WW-1] ^ i_b[WW-1];
                    end
                    default: begin
                        r_x   <= i_b;
                        r_y   <= i_a;
                        r_neg <= 1'b0;
                    end
                endcase
            end else if (r_busy) begin
                if (r_op == MD_MUL) begin
                    // shift-add, low word only
                    if (r_y[0]) r_acc <= r_acc + r_x;
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end else begin
                    // restoring divide, quotient shifts into r_y
                    if (fits) begin
                        r_acc <= WW'(rem_sh - {1'b0, r_x});
                        r_y   <= {r_y[WW-2:0], 1'b1};
                    end else begin
                        r_acc <= rem_sh[WW-1:0];
                        r_y   <= {r_y[WW-2:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/sme_back.sv]
// Back end: sequencer that carries out one item against the data memory,
// stack pointer and label table. Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_back import sme_pkg::*; #(
    parameter int MEM_DEPTH   = 1024,
    parameter int LABEL_DEPTH = 256,
    parameter int PROG_DEPTH  = 4096,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_qent                 i_q_ent,
    output logic                  o_q_pop,
    output t_be_status            o_status,
    output t_md_req               o_md_req,
    output logic [WORD_WIDTH-1:0] o_md_a,
    output logic [WORD_WIDTH-1:0] o_md_b,
    input  logic                  i_md_done,
    input  logic [WORD_WIDTH-1:0] i_md_result,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_item
);

    localparam int WW = WORD_WIDTH;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int LW = $clog2(LABEL_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH);
    // instr_addr needs reduction only for a short program space
    localparam bit NEED_MOD = PROG_DEPTH < 4096;
    localparam int RS       = 24;
    localparam int RECIP    = (1 << RS) / PROG_DEPTH;
    // returned word is reduced 16 bits at a time by reciprocal
    localparam int CH       = 16;
    localparam int NCH      = (WW + CH - 1) / CH;
    localparam int XW       = NCH * CH;
    localparam logic [31:0] RECIP32 = 32'((64'd1 << 32) / 64'(PROG_DEPTH));

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MOD1, S_MOD2, S_DISP, S_EXEC, S_RD2, S_BIN,
        S_MD, S_RET, S_RET2, S_ALR, S_AISS, S_ACLR, S_DAR, S_DISS, S_DONE
    } t_state;

    t_state        r_state, n_state;
    t_qent         r_e, n_e;
    logic [PW-1:0] r_pcm, n_pcm;
    logic [PW-1:0] r_next, n_next;
    logic [AW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_clr, n_clr;
    logic [9:0]    r_k, n_k;
    logic [11:0]   r_q, n_q;
    logic [WW-1:0] r_x, n_x;
    logic [2:0]    r_st, n_st;
    logic          r_pv, n_pv;
    logic [31:0]   r_pval, n_pval;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    logic [XW-1:0] r_xs, n_xs;
    logic [31:0]   r_rv, n_rv;
    logic [31:0]   r_rq, n_rq;
    logic [2:0]    r_rc, n_rc;

    // memories
    logic [WW-1:0] r_mem [MEM_DEPTH];
    logic [WW-1:0] r_rdata;
    logic [PW-1:0] r_lab [LABEL_DEPTH];
    logic [PW-1:0] r_lab_q;

    logic          mem_we, mem_re, lab_we, lab_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [WW-1:0] mem_wd;
    logic [LW-1:0] lab_wa, lab_ra;
    logic [PW-1:0] lab_wd;

    // derived values
    logic [31:0]   sp32, a32, n32, addr32, mr;
    logic          room1, roomn, a_bad, lab_bad, blk_bad;
    logic [AW-1:0] sp_p1, sp_m1;
    logic [WW-1:0] xw, yw, bin_res;
    logic signed [WW-1:0] xs, ys;
    logic [4:0]    op;
    logic [XW-1:0] rd_pad;
    logic [63:0]   rq_prod;
    logic [31:0]   rv_rem, rv_mod;

    assign sp32    = 32'(r_sp);
    assign a32     = 32'(r_e.item.arg_a);
    assign n32     = 32'(r_e.item.arg_b);
    assign addr32  = 32'(r_e.item.instr_addr);
    assign room1   = (sp32 + 32'd1) <= 32'(MEM_DEPTH - 1);
    assign roomn   = (sp32 + n32) <= 32'(MEM_DEPTH - 1);
    assign a_bad   = a32 >= 32'(MEM_DEPTH);
    assign lab_bad = a32 >= 32'(LABEL_DEPTH);
    assign blk_bad = (n32 != 32'd0) && ((a32 + n32 - 32'd1) >= 32'(MEM_DEPTH));
    assign sp_p1   = AW'(sp32 + 32'd1);
    assign sp_m1   = AW'(sp32 - 32'd1);
    assign op      = r_e.item.opcode;

    // modulo step: estimate is low by at most one
    assign mr = addr32 - 32'(r_q) * 32'(PROG_DEPTH);

    // return address reduction: partial value below 2^32, estimate low by at most one
    assign rd_pad  = XW'(r_rdata);
    assign rq_prod = 64'(r_rv) * 64'(RECIP32);
    assign rv_rem  = r_rv - r_rq * 32'(PROG_DEPTH);
    assign rv_mod  = (rv_rem >= 32'(PROG_DEPTH)) ? rv_rem - 32'(PROG_DEPTH) : rv_rem;

    // binary op: x from top of stack, y below it
    assign xw = r_x;
    assign yw = r_rdata;
    assign xs = signed'(xw);
    assign ys = signed'(yw);
    always_comb begin
        unique case (op)
            OP_ADD:  bin_res = yw + xw;
            OP_SUB:  bin_res = yw - xw;
            OP_AND:  bin_res = WW'((xw != '0) && (yw != '0));
            OP_OR:   bin_res = WW'((xw != '0) || (yw != '0));
            OP_CME:  bin_res = WW'(ys < xs);
            OP_CMA:  bin_res = WW'(xs < ys);
            OP_CEQ:  bin_res = WW'(yw == xw);
            OP_CDIF: bin_res = WW'(yw != xw);
            OP_CMEQ: bin_res = WW'(!(xs < ys));
            OP_CMAQ: bin_res = WW'(!(ys < xs));
            default: bin_res = yw + xw;
        endcase
    end

    function automatic logic [PW-1:0] pc_inc(input logic [PW-1:0] p);
        pc_inc = (32'(p) == 32'(PROG_DEPTH - 1)) ? '0 : PW'(32'(p) + 32'd1);
    endfunction

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_valid           = r_out_valid;
    assign o_item            = r_out;

    // next-state and memory control
    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_pcm       = r_pcm;
        n_next      = r_next;
        n_sp        = r_sp;
        n_clr       = r_clr;
        n_k         = r_k;
        n_q         = r_q;
        n_x         = r_x;
        n_st        = r_st;
        n_pv        = r_pv;
        n_pval      = r_pval;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_xs        = r_xs;
        n_rv        = r_rv;
        n_rq        = r_rq;
        n_rc        = r_rc;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = sp_p1;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = r_sp;
        lab_we      = 1'b0;
        lab_wa      = LW'(r_e.item.arg_a);
        lab_wd      = r_pcm;
        lab_re      = 1'b0;
        lab_ra      = LW'(r_e.item.arg_a);
        o_md_req    = '{start: 1'b0, op: MD_MUL};
        o_md_a      = yw;
        o_md_b      = xw;

        if (r_out_valid && !i_stall) n_out_valid = 1'b0;

        unique case (r_state)
            // zero the data memory after reset
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (32'(r_clr) == 32'(MEM_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_e     = i_q_ent;
                    n_st    = ST_OK;
                    n_pv    = 1'b0;
                    n_pval  = '0;
                    if (NEED_MOD) begin
                        n_state = S_MOD1;
                    end else begin
                        n_pcm   = PW'(i_q_ent.item.instr_addr);
                        n_state = S_DISP;
                    end
                end
            end
            // instr_addr mod PROG_DEPTH by reciprocal
            S_MOD1: begin
                n_q     = 12'((addr32 * 32'(RECIP)) >> RS);
                n_state = S_MOD2;
            end
            S_MOD2: begin
                n_pcm   = (mr >= 32'(PROG_DEPTH)) ? PW'(mr - 32'(PROG_DEPTH)) : PW'(mr);
                n_state = S_DISP;
            end
            // check and issue first accesses
            S_DISP: begin
                n_next  = pc_inc(r_pcm);
                n_state = S_DONE;
                unique case (r_e.cls)
                    C_DEF: begin
                        lab_we = !lab_bad;
                    end
                    C_PUSHIN: begin
                        if (!room1) begin
                            n_st = ST_OVER;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = sp_p1;
                            mem_wd = (op == OP_LDC) ? WW'(r_e.item.const_value)
                                                    : WW'(r_e.item.read_value);
                            n_sp   = sp_p1;
                        end
                    end
                    C_LDV: begin
                        if (a_bad)       n_st = ST_ADDR;
                        else if (!room1) n_st = ST_OVER;
                        else begin
                            mem_re  = 1'b1;
                            mem_ra  = AW'(a32);
                            n_state = S_EXEC;
                        end
                    end
                    C_STR: begin
                        if (a_bad)              n_st = ST_ADDR;
                        else if (r_sp == '0)    n_st = ST_UNDER;
                        else begin
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                    end
                    C_JMP: begin
                        if (lab_bad) n_st = ST_ADDR;
                        else begin
                            lab_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                    end
                    C_JMPF: begin
                        if (lab_bad)            n_st = ST_ADDR;
                        else if (r_sp == '0)    n_st = ST_UNDER;
                        else begin
                            lab_re  = 1'b1;
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                    end
                    C_CALL: begin
                        if (lab_bad)     n_st = ST_ADDR;
                        else if (!room1) n_st = ST_OVER;
                        else begin
                            lab_re  = 1'b1;
                            mem_we  = 1'b1;
                            mem_wa  = sp_p1;
                            mem_wd  = WW'(r_pcm);
                            n_sp    = sp_p1;
                            n_state = S_EXEC;
                        end
                    end
                    C_BIN: begin
                        if (sp32 < 32'd2) n_st = ST_UNDER;
                        else begin
                            mem_re  = 1'b1;
                            n_state = S_RD2;
                        end
                    end
                    C_UN: begin
                        if (r_sp == '0) n_st = ST_UNDER;
                        else begin
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                    end
                    C_ALLOC: begin
                        if (blk_bad)     n_st = ST_ADDR;
                        else if (!roomn) n_st = ST_OVER;
                        else if (n32 != 32'd0) begin
                            n_k     = '0;
                            mem_re  = 1'b1;
                            mem_ra  = AW'(a32);
                            n_state = S_ALR;
                        end
                    end
                    C_DALLOC: begin
                        if (blk_bad)         n_st = ST_ADDR;
                        else if (sp32 < n32) n_st = ST_UNDER;
                        else if (n32 != 32'd0) begin
                            n_k     = r_e.item.arg_b;
                            mem_re  = 1'b1;
                            n_state = S_DAR;
                        end
                    end
                    C_HLT: begin
                        n_st   = ST_HALT;
                        n_next = r_pcm;
                    end
                    default: ;
                endcase
            end
            // second step with read data and label in hand
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_e.cls)
                    C_LDV: begin
                        mem_we = 1'b1;
                        mem_wa = sp_p1;
                        mem_wd = r_rdata;
                        n_sp   = sp_p1;
                    end
                    C_STR: begin
                        mem_we = 1'b1;
                        mem_wa = AW'(a32);
                        mem_wd = r_rdata;
                        n_sp   = sp_m1;
                    end
                    C_JMP, C_CALL: begin
                        n_next = pc_inc(r_lab_q);
                    end
                    C_JMPF: begin
                        n_sp = sp_m1;
                        if (r_rdata == '0) n_next = pc_inc(r_lab_q);
                    end
                    default: begin
                        // unary ops
                        if (op == OP_NEG) begin
                            mem_we = 1'b1;
                            mem_wa = r_sp;
                            mem_wd = WW'(r_rdata == '0);
                        end else if (op == OP_INV) begin
                            mem_we = 1'b1;
                            mem_wa = r_sp;
                            mem_wd = WW'(0) - r_rdata;
                        end else if (op == OP_PRN) begin
                            n_sp   = sp_m1;
                            n_pv   = 1'b1;
                            n_pval = 32'(signed'(r_rdata));
                        end else begin
                            // return: reduce the popped word, top 16 bits first
                            n_sp    = sp_m1;
                            n_rv    = 32'(rd_pad[XW-1 -: CH]);
                            n_xs    = rd_pad << CH;
                            n_rc    = 3'd1;
                            n_state = S_RET;
                        end
                    end
                endcase
            end
            // hold x, read y
            S_RD2: begin
                n_x     = r_rdata;
                mem_re  = 1'b1;
                mem_ra  = sp_m1;
                n_state = S_BIN;
            end
            S_BIN: begin
                if (op == OP_DIV && xw == '0) begin
                    n_st    = ST_DIVZERO;
                    n_state = S_DONE;
                end else if (op == OP_MULT || op == OP_DIV) begin
                    o_md_req = '{start: 1'b1, op: (op == OP_MULT) ? MD_MUL : MD_SDIV};
                    n_state  = S_MD;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = sp_m1;
                    mem_wd  = bin_res;
                    n_sp    = sp_m1;
                    n_state = S_DONE;
                end
            end
            S_MD: begin
                if (i_md_done) begin
                    mem_we  = 1'b1;
                    mem_wa  = sp_m1;
                    mem_wd  = i_md_result;
                    n_sp    = sp_m1;
                    n_state = S_DONE;
                end
            end
            // quotient estimate of the partial value
            S_RET: begin
                n_rq    = 32'(rq_prod >> 32);
                n_state = S_RET2;
            end
            // partial remainder, then fold in the next 16 bits
            S_RET2: begin
                if (32'(r_rc) == 32'(NCH)) begin
                    n_next  = pc_inc(PW'(rv_mod));
                    n_state = S_DONE;
                end else begin
                    n_rv    = {rv_mod[CH-1:0], r_xs[XW-1 -: CH]};
                    n_xs    = r_xs << CH;
                    n_rc    = r_rc + 1'b1;
                    n_state = S_RET;
                end
            end
            // block push: write word k, then read word k+1
            S_ALR: begin
                mem_we = 1'b1;
                mem_wa = sp_p1;
                mem_wd = r_rdata;
                n_sp   = sp_p1;
                if (32'(r_k) + 32'd1 == n32) begin
                    n_k     = '0;
                    n_state = S_ACLR;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_AISS;
                end
            end
            S_AISS: begin
                mem_re  = 1'b1;
                mem_ra  = AW'(a32 + 32'(r_k));
                n_state = S_ALR;
            end
            S_ACLR: begin
                mem_we = 1'b1;
                mem_wa = AW'(a32 + 32'(r_k));
                mem_wd = '0;
                n_k    = r_k + 1'b1;
                if (32'(r_k) + 32'd1 == n32) n_state = S_DONE;
            end
            // block pop, highest word first
            S_DAR: begin
                mem_we = 1'b1;
                mem_wa = AW'(a32 + 32'(r_k) - 32'd1);
                mem_wd = r_rdata;
                n_sp   = sp_m1;
                n_k    = r_k - 1'b1;
                n_state = (r_k == 10'd1) ? S_DONE : S_DISS;
            end
            S_DISS: begin
                mem_re  = 1'b1;
                n_state = S_DAR;
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out       = '{next_pc: 12'(r_next), print_valid: r_pv,
                                print_value: r_pval, status: r_st};
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_e    <= n_e;
        r_pcm  <= n_pcm;
        r_next <= n_next;
        r_k    <= n_k;
        r_q    <= n_q;
        r_x    <= n_x;
        r_st   <= n_st;
        r_pv   <= n_pv;
        r_pval <= n_pval;
        r_out  <= n_out;
        r_xs   <= n_xs;
        r_rv   <= n_rv;
        r_rq   <= n_rq;
        r_rc   <= n_rc;
    end

    // data memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    // label table
    always_ff @(posedge i_clk) begin
        if (lab_we) r_lab[lab_wa] <= lab_wd;
        if (lab_re) r_lab_q <= r_lab[lab_ra];
    end

endmodule

[rtl/core/stack_machine_execute_top.sv]
// Stack machine execute block: front end, item queue, back end sequencer
// and shared multiply/divide unit. Depends on sme_pkg and all sme_ modules.
// Back end steps: S_IDLE, S_DISP, S_DONE for single-step items; loads, stores,
// jumps and unary ops add S_EXEC, binary ops S_RD2 and S_BIN; a short PROG_DEPTH
// adds S_MOD1 and S_MOD2. MULT and DIV wait in S_MD on the bit-serial unit,
// RETURN loops S_RET, S_RET2 per 16 bits of word, ALLOC S_ALR, S_AISS per word,
// then S_ACLR per word, DALLOC S_DAR, S_DISS per word. One item at a time in
// the back end, next taken in the cycle after the result is accepted; the queue
// accepts up to two ahead. Reset zeroes the data memory, inputs stalled.
`timescale 1ns / 1ps

module stack_machine_execute_top import sme_pkg::*; #(
    parameter int MEM_DEPTH   = 1024,
    parameter int LABEL_DEPTH = 256,
    parameter int PROG_DEPTH  = 4096,
    parameter int WORD_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic                  q_push, q_pop, q_full, q_valid;
    t_qent                 q_in, q_out;
    t_be_status            be_status;
    t_md_req               md_req;
    logic [WORD_WIDTH-1:0] md_a, md_b, md_result;
    logic                  md_done;

    sme_front u_front (
        .i_item   (i_item),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .i_status (be_status),
        .o_push   (q_push),
        .o_ent    (q_in)
    );

    sme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_out)
    );

    sme_muldiv #(.WORD_WIDTH(WORD_WIDTH)) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (md_a),
        .i_b      (md_b),
        .o_done   (md_done),
        .o_result (md_result)
    );

    sme_back #(
        .MEM_DEPTH   (MEM_DEPTH),
        .LABEL_DEPTH (LABEL_DEPTH),
        .PROG_DEPTH  (PROG_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_out),
        .o_q_pop     (q_pop),
        .o_status    (be_status),
        .o_md_req    (md_req),
        .o_md_a      (md_a),
        .o_md_b      (md_b),
        .i_md_done   (md_done),
        .i_md_result (md_result),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

[dv/sme_checker.sv]
// Checker for the stack machine execute block: watches both channels,
// predicts every result item and compares it. Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_checker import sme_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int MEM_D = 1024;
    localparam int LAB_D = 256;

    logic [31:0] mem_model [MEM_D];
    logic [9:0]  sp_model;
    logic [11:0] label_model [LAB_D];
    t_out_item   expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic less_s(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Executes one item on the model state and returns the expected result
    function automatic t_out_item execute_item(t_in_item it);
        t_out_item r;
        logic [31:0] x, y, q;
        int k;
        int a, n;
        a = it.arg_a;
        n = it.arg_b;
        r.next_pc = it.instr_addr + 12'd1;
        r.print_valid = 1'b0;
        r.print_value = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_DEF) begin
            if (a < LAB_D) label_model[a] = it.instr_addr;
        end else begin
            case (it.opcode)
                OP_LDC, OP_RD: begin
                    if (sp_model == 10'(MEM_D - 1)) r.status = ST_OVER;
                    else begin
                        sp_model++;
                        mem_model[sp_model] = (it.opcode == OP_LDC) ?
                            it.const_value : it.read_value;
                    end
                end
                OP_LDV: begin
                    if (sp_model == 10'(MEM_D - 1)) r.status = ST_OVER;
                    else begin
                        x = mem_model[a];
                        sp_model++;
                        mem_model[sp_model] = x;
                    end
                end
                OP_STR: begin
                    if (sp_model == 0) r.status = ST_UNDER;
                    else begin
                        x = mem_model[sp_model];
                        sp_model--;
                        mem_model[a] = x;
                    end
                end
                OP_JMP, OP_JMPF, OP_CALL: begin
                    if (a >= LAB_D) r.status = ST_ADDR;
                    else if (it.opcode == OP_JMP)
                        r.next_pc = label_model[a] + 12'd1;
                    else if (it.opcode == OP_JMPF) begin
                        if (sp_model == 0) r.status = ST_UNDER;
                        else begin
                            x = mem_model[sp_model];
                            sp_model--;
                            if (x == 0) r.next_pc = label_model[a] + 12'd1;
                        end
                    end else begin
                        if (sp_model == 10'(MEM_D - 1)) r.status = ST_OVER;
                        else begin
                            sp_model++;
                            mem_model[sp_model] = 32'(it.instr_addr);
                            r.next_pc = label_model[a] + 12'd1;
                        end
                    end
                end
                OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_OR, OP_CME, OP_CMA,
                OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ: begin
                    if (sp_model < 2) r.status = ST_UNDER;
                    else if (it.opcode == OP_DIV && mem_model[sp_model] == 0)
                        r.status = ST_DIVZERO;
                    else begin
                        x = mem_model[sp_model];
                        y = mem_model[sp_model - 10'd1];
                        sp_model -= 10'd2;
                        case (it.opcode)
                            OP_ADD:  q = y + x;
                            OP_SUB:  q = y - x;
                            OP_MULT: q = y * x;
                            OP_DIV: begin
                                // most negative over -1 wraps to itself
                                if (y == 32'h8000_0000 && x == '1) q = y;
                                else q = $signed(y) / $signed(x);
                            end
                            OP_AND:  q = 32'(x != 0 && y != 0);
                            OP_OR:   q = 32'(x != 0 || y != 0);
                            OP_CME:  q = 32'(less_s(y, x));
                            OP_CMA:  q = 32'(less_s(x, y));
                            OP_CEQ:  q = 32'(y == x);
                            OP_CDIF: q = 32'(y != x);
                            OP_CMEQ: q = 32'(!less_s(x, y));
                            default: q = 32'(!less_s(y, x));
                        endcase
                        sp_model++;
                        mem_model[sp_model] = q;
                    end
                end
                OP_NEG, OP_RETURN, OP_PRN, OP_INV: begin
                    if (sp_model == 0) r.status = ST_UNDER;
                    else begin
                        x = mem_model[sp_model];
                        sp_model--;
                        if (it.opcode == OP_NEG) begin
                            sp_model++;
                            mem_model[sp_model] = 32'(x == 0);
                        end else if (it.opcode == OP_INV) begin
                            sp_model++;
                            mem_model[sp_model] = -x;
                        end else if (it.opcode == OP_RETURN)
                            r.next_pc = x[11:0] + 12'd1;
                        else begin
                            r.print_valid = 1'b1;
                            r.print_value = x;
                        end
                    end
                end
                OP_ALLOC, OP_DALLOC: begin
                    if (n > 0 && a + n - 1 >= MEM_D) r.status = ST_ADDR;
                    else if (it.opcode == OP_ALLOC) begin
                        if (int'(sp_model) + n > MEM_D - 1) r.status = ST_OVER;
                        else begin
                            for (k = 0; k < n; k++) begin
                                x = mem_model[a + k];
                                sp_model++;
                                mem_model[sp_model] = x;
                            end
                            for (k = 0; k < n; k++) mem_model[a + k] = '0;
                        end
                    end else begin
                        if (int'(sp_model) < n) r.status = ST_UNDER;
                        else begin
                            for (k = n; k > 0; k--) begin
                                x = mem_model[sp_model];
                                sp_model--;
                                mem_model[a + k - 1] = x;
                            end
                        end
                    end
                end
                OP_HLT: begin
                    r.status = ST_HALT;
                    r.next_pc = it.instr_addr;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Predict on input accepts, compare on output accepts
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_D; i++) mem_model[i] <= '0;
            sp_model <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(execute_item(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (exp_item != i_out_item) o_fail_count <= o_fail_count + 1;
                    if (exp_item.next_pc != i_out_item.next_pc)
                        $error("next_pc exp %0d got %0d", exp_item.next_pc,
                               i_out_item.next_pc);
                    if (exp_item.print_valid != i_out_item.print_valid)
                        $error("print_valid exp %0d got %0d", exp_item.print_valid,
                               i_out_item.print_valid);
                    if (exp_item.print_value != i_out_item.print_value)
                        $error("print_value exp %0d got %0d", exp_item.print_value,
                               i_out_item.print_value);
                    if (exp_item.status != i_out_item.status)
                        $error("status exp %0d got %0d", exp_item.status,
                               i_out_item.status);
                end
            end
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench top for stack_machine_execute_top: clock, reset, stimulus
// and verdict. Depends on sme_pkg, the block and sme_checker.
`timescale 1ns / 1ps

module tb_top;
    import sme_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    logic      label_set [256];
    int        sp_guess;

    always #2 clk = ~clk;

    stack_machine_execute_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_item(in_item), .o_valid(out_valid), .i_stall(out_stall),
        .o_item(out_item)
    );

    sme_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_item(in_item), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_item(out_item), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stall pattern: a random stall, drawn anew each cycle
    always @(posedge clk) begin
        int mode;
        mode = ($urandom_range(0, 199) < 100) ? 0 : 1;
        out_stall <= (mode == 1) ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    // Presents one item and waits for its accept
    task automatic send_item(t_in_item it);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Builds an item from an opcode and its two arguments
    function automatic t_in_item make_item(logic [4:0] op, int a, int b);
        t_in_item it;
        it.cmd         = CMD_EXEC;
        it.opcode      = op;
        it.arg_a       = 10'(a);
        it.arg_b       = 10'(b);
        it.instr_addr  = 12'($urandom);
        it.read_value  = $urandom;
        it.const_value = $urandom;
        return it;
    endfunction

    function automatic t_in_item label_item(int num, int addr);
        t_in_item it;
        it = make_item(OP_NOP, num, 0);
        it.cmd = CMD_DEF;
        it.instr_addr = 12'(addr);
        return it;
    endfunction

    function automatic int defined_label();
        int l;
        for (int t = 0; t < 64; t++) begin
            l = $urandom_range(0, 255);
            if (label_set[l]) return l;
        end
        return 0;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int r, op, a, b;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            a = $urandom_range(0, 1023);
            it = label_item(a, $urandom);
        end else begin
            op = (r < 8) ? $urandom_range(0, 31) : $urandom_range(0, 26);
            a  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 31);
            b  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 6);
            if (op == OP_JMP || op == OP_JMPF || op == OP_CALL)
                a = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 1023)
                                                : defined_label();
            // push more often while the stack is shallow so it has depth
            if ($urandom_range(0, 3) == 0 && sp_guess < 4) op = OP_LDC;
            it = make_item(5'(op), a, b);
            if ($urandom_range(0, 3) == 0) it.const_value = $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) it.instr_addr = 12'hFFF;
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        int bursts;
        int len;
        for (int i = 0; i < 256; i++) label_set[i] = 1'b0;
        sp_guess = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: labels, a selection of opcodes, field extremes and the error paths
        send_item(label_item(0, 0));
        send_item(label_item(255, 4095));
        send_item(label_item(300, 17));
        label_set[0] = 1'b1;
        label_set[255] = 1'b1;
        send_item(make_item(OP_ADD, 0, 0));        // underflow
        send_item(make_item(OP_PRN, 0, 0));        // underflow
        it = make_item(OP_LDC, 0, 0); it.const_value = 32'h8000_0000; send_item(it);
        it = make_item(OP_RD, 0, 0); it.read_value = 32'hFFFF_FFFF; send_item(it);
        send_item(make_item(OP_DIV, 0, 0));        // min / -1
        it = make_item(OP_LDC, 0, 0); it.const_value = 0; send_item(it);
        send_item(make_item(OP_DIV, 0, 0));        // divide by zero
        send_item(make_item(OP_STR, 1023, 0));
        send_item(make_item(OP_LDV, 1023, 0));
        send_item(make_item(OP_JMPF, 255, 0));
        send_item(make_item(OP_JMP, 300, 0));      // label out of range
        send_item(make_item(OP_CALL, 0, 0));
        send_item(make_item(OP_RETURN, 0, 0));
        send_item(make_item(OP_ALLOC, 1020, 10));  // block past end
        send_item(make_item(OP_ALLOC, 1023, 1));
        send_item(make_item(OP_DALLOC, 0, 1023));  // underflow
        send_item(make_item(OP_DALLOC, 1014, 2));
        send_item(make_item(OP_ALLOC, 0, 1023));   // fills the stack exactly
        send_item(make_item(OP_ALLOC, 5, 0));
        send_item(make_item(OP_HLT, 0, 0));
        send_item(make_item(5'd31, 0, 0));

        // Pause until every expectation has drained
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);

        // Overflow the full stack with one large block and pushes, then drain it
        send_item(make_item(OP_ALLOC, 0, 1000));
        for (int i = 0; i < 30; i++) send_item(make_item(OP_LDC, 0, 0));
        send_item(make_item(OP_DALLOC, 0, 1000));
        for (int i = 0; i < 30; i++) send_item(make_item(OP_INV, 0, 0));

        // Random bursts
        bursts = 0;
        while (bursts < 900) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                it = random_item();
                if (it.cmd == CMD_DEF && it.arg_a < 256) label_set[it.arg_a] = 1'b1;
                if (it.opcode == OP_LDC || it.opcode == OP_RD || it.opcode == OP_LDV)
                    sp_guess++;
                else if (sp_guess > 0) sp_guess--;
                send_item(it);
            end
            bursts += len;
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #100_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
